// ===== rtl/utf8ucs2_pkg.sv =====
package utf8ucs2_pkg;

    localparam int BYTE_W  = 8;
    localparam int UNIT_W  = 16;
    localparam int LEN_W   = 3;
    localparam int DATA_W  = 7;
    localparam int QDEPTH  = 4;
    localparam int QPTR_W  = 2;
    localparam int QCNT_W  = 3;
    localparam int PADDR_W = 3;
    localparam int PDATA_W = 32;

    localparam logic [UNIT_W-1:0] UNIT_MAX      = 16'hFFFF;
    localparam logic [UNIT_W-1:0] MAX_UNITS_RST = 16'hFFFF;
    localparam logic [LEN_W-1:0]  SHORT_SEQ_MAX = 3'd3;

    // register index is paddr[2]
    localparam logic REG_MAX_UNITS = 1'b0;

    // lead byte class by count of leading ones
    typedef enum logic [2:0] {
        LC_ASCII,
        LC_CONT,
        LC_TWO,
        LC_THREE,
        LC_FOUR,
        LC_FIVE,
        LC_SIX,
        LC_INVALID
    } lead_class_t;

    typedef struct packed {
        lead_class_t         cls;
        logic [DATA_W-1:0]   data;
        logic                last;
    } item_t;

    typedef struct packed {
        logic [UNIT_W-1:0] code_unit;
        logic              unit_valid;
        logic              string_end;
        logic [UNIT_W-1:0] unit_count;
        logic              limit_hit;
    } result_t;

    function automatic logic [LEN_W-1:0] seq_len(input lead_class_t c);
        logic [LEN_W-1:0] n;
        unique case (c)
            LC_TWO:   n = 3'd2;
            LC_THREE: n = 3'd3;
            LC_FOUR:  n = 3'd4;
            LC_FIVE:  n = 3'd5;
            LC_SIX:   n = 3'd6;
            default:  n = 3'd0;
        endcase
        return n;
    endfunction

endpackage

// ===== rtl/utf8_to_ucs2_decoder_unit.sv =====
// A byte accepted at s_* is written to the request queue; the decode stage then takes
//   it from the queue head and loads the output register that drives m_*.
// Throughput: one byte per cycle sustained while m_tready does not stall the output;
//   bytes that give no result still pass through the decode stage.
// Reset: aresetn is synchronous, active low; it empties the queue and output
//   register, clears per-string state and sets max_units to 0xFFFF.
module utf8_to_ucs2_decoder_unit (
    input  logic                            aclk,
    input  logic                            aresetn,

    // input byte stream
    input  logic                            s_tvalid,
    output logic                            s_tready,
    input  logic [utf8ucs2_pkg::BYTE_W-1:0]  s_tdata,   // [7:0] in_byte
    input  logic                            s_tlast,   // last_byte

    // decoded unit stream
    output logic                            m_tvalid,
    input  logic                            m_tready,
    output logic [2*utf8ucs2_pkg::UNIT_W-1:0] m_tdata, // [15:0] code_unit, [31:16] unit_count
    output logic                            m_tlast,   // string_end
    output logic [1:0]                      m_tuser,   // [0] unit_valid, [1] limit_hit

    // register port
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [utf8ucs2_pkg::PADDR_W-1:0] paddr,
    input  logic [utf8ucs2_pkg::PDATA_W-1:0] pwdata,
    output logic [utf8ucs2_pkg::PDATA_W-1:0] prdata,
    output logic                            pready
);
    import utf8ucs2_pkg::*;

    logic [UNIT_W-1:0] max_units_reg;

    // front -> queue
    logic  push_valid, push_ready;
    item_t push_item;

    // queue -> back
    logic  pop_valid, pop_ready;
    item_t pop_item;

    result_t res;

    // register write on the access phase; only paddr[2] decodes the register
    assign pready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            max_units_reg <= MAX_UNITS_RST;
        end else if (psel && penable && pwrite && pready && paddr[2] == REG_MAX_UNITS) begin
            max_units_reg <= pwdata[UNIT_W-1:0];
        end
    end

    assign prdata = (paddr[2] == REG_MAX_UNITS) ? PDATA_W'(max_units_reg) : '0;

    // front: takes each byte and tags it with its lead class
    utf8ucs2_front u_front (
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tlast    (s_tlast),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_item  (push_item)
    );

    // short request queue decouples input from the decode stage
    utf8ucs2_fifo u_fifo (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_item  (push_item),
        .pop_valid  (pop_valid),
        .pop_ready  (pop_ready),
        .pop_item   (pop_item)
    );

    // back: sequence state, unit limit, registered result
    utf8ucs2_back u_back (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .max_units  (max_units_reg),
        .item_valid (pop_valid),
        .item_ready (pop_ready),
        .item       (pop_item),
        .res_valid  (m_tvalid),
        .res_ready  (m_tready),
        .res        (res)
    );

    assign m_tdata = {res.unit_count, res.code_unit};
    assign m_tlast = res.string_end;
    assign m_tuser = {res.limit_hit, res.unit_valid};

endmodule

// ===== rtl/utf8ucs2_front.sv =====
module utf8ucs2_front (
    input  logic                           s_tvalid,
    output logic                           s_tready,
    input  logic [utf8ucs2_pkg::BYTE_W-1:0] s_tdata,   // in_byte
    input  logic                           s_tlast,   // last_byte
    output logic                           push_valid,
    input  logic                           push_ready,
    output utf8ucs2_pkg::item_t            push_item
);
    import utf8ucs2_pkg::*;

    lead_class_t cls;

    // count leading ones of the byte
    always_comb begin
        priority if (!s_tdata[7]) begin
            cls = LC_ASCII;
        end else if (!s_tdata[6]) begin
            cls = LC_CONT;
        end else if (!s_tdata[5]) begin
            cls = LC_TWO;
        end else if (!s_tdata[4]) begin
            cls = LC_THREE;
        end else if (!s_tdata[3]) begin
            cls = LC_FOUR;
        end else if (!s_tdata[2]) begin
            cls = LC_FIVE;
        end else if (!s_tdata[1]) begin
            cls = LC_SIX;
        end else begin
            cls = LC_INVALID;
        end
    end

    assign push_item.cls  = cls;
    assign push_item.data = s_tdata[DATA_W-1:0];
    assign push_item.last = s_tlast;
    assign push_valid     = s_tvalid;
    assign s_tready       = push_ready;

endmodule

// ===== rtl/utf8ucs2_fifo.sv =====
module utf8ucs2_fifo (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                push_valid,
    output logic                push_ready,
    input  utf8ucs2_pkg::item_t push_item,
    output logic                pop_valid,
    input  logic                pop_ready,
    output utf8ucs2_pkg::item_t pop_item
);
    import utf8ucs2_pkg::*;

    item_t               mem_reg [QDEPTH];
    logic [QPTR_W-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [QCNT_W-1:0]   cnt_reg, cnt_next;
    logic                do_push, do_pop;

    assign push_ready = (cnt_reg != QCNT_W'(QDEPTH));
    assign pop_valid  = (cnt_reg != '0);
    assign pop_item   = mem_reg[rd_ptr_reg];
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop_valid && pop_ready;

    always_comb begin
        wr_ptr_next = do_push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = do_pop  ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        cnt_next    = cnt_reg + QCNT_W'(do_push) - QCNT_W'(do_pop);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (do_push) begin
            mem_reg[wr_ptr_reg] <= push_item;
        end
    end

    a_cnt_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        cnt_reg <= QCNT_W'(QDEPTH))
        else $error("queue count over depth");

    a_push_seen: assert property (@(posedge aclk) disable iff (!aresetn)
        do_push && !pop_valid |=> pop_valid)
        else $error("pushed request not visible at queue head");

endmodule

// ===== rtl/utf8ucs2_back.sv =====
module utf8ucs2_back (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic [utf8ucs2_pkg::UNIT_W-1:0] max_units,
    input  logic                           item_valid,
    output logic                           item_ready,
    input  utf8ucs2_pkg::item_t            item,
    output logic                           res_valid,
    input  logic                           res_ready,
    output utf8ucs2_pkg::result_t          res
);
    import utf8ucs2_pkg::*;

    logic [LEN_W-1:0]  bytes_left_reg, bytes_left_next;
    logic [UNIT_W-1:0] partial_reg, partial_next;
    logic [LEN_W-1:0]  seq_kind_reg, seq_kind_next;
    logic [UNIT_W-1:0] count_reg, count_next;
    logic              stopped_reg, stopped_next;
    logic              out_valid_reg;
    result_t           out_reg;

    logic              emit;
    logic [UNIT_W-1:0] unit;
    logic [LEN_W-1:0]  left_dec;
    logic [LEN_W-1:0]  lead_len;
    logic              take;
    result_t           res_next;

    assign item_ready = !out_valid_reg || res_ready;
    assign take       = item_valid && item_ready;
    assign lead_len   = seq_len(item.cls);
    assign left_dec   = bytes_left_reg - 1'b1;

    always_comb begin
        bytes_left_next = bytes_left_reg;
        partial_next    = partial_reg;
        seq_kind_next   = seq_kind_reg;
        stopped_next    = stopped_reg;
        emit            = 1'b0;
        unit            = '0;

        if (item_valid && !stopped_reg) begin
            if (bytes_left_reg != '0) begin
                // continuation byte, taken unchecked
                if (seq_kind_reg <= SHORT_SEQ_MAX) begin
                    partial_next = {partial_reg[UNIT_W-7:0], item.data[5:0]};
                end
                bytes_left_next = left_dec;
                if (left_dec == '0) begin
                    unit          = (seq_kind_reg <= SHORT_SEQ_MAX) ? partial_next : '0;
                    emit          = 1'b1;
                    partial_next  = '0;
                    seq_kind_next = '0;
                end
            end else if (count_reg >= max_units || count_reg == UNIT_MAX) begin
                stopped_next = 1'b1;
            end else begin
                unique case (item.cls)
                    LC_ASCII: begin
                        unit = UNIT_W'(item.data);
                        emit = 1'b1;
                    end
                    LC_TWO: begin
                        seq_kind_next   = lead_len;
                        bytes_left_next = lead_len - 1'b1;
                        partial_next    = UNIT_W'(item.data[4:0]);
                    end
                    LC_THREE: begin
                        seq_kind_next   = lead_len;
                        bytes_left_next = lead_len - 1'b1;
                        partial_next    = UNIT_W'(item.data[3:0]);
                    end
                    LC_FOUR, LC_FIVE, LC_SIX: begin
                        seq_kind_next   = lead_len;
                        bytes_left_next = lead_len - 1'b1;
                        partial_next    = '0;
                    end
                    LC_CONT, LC_INVALID: begin
                        // stray continuation or 0xFE/0xFF: dropped
                    end
                endcase
            end
        end

        count_next = count_reg + UNIT_W'(emit);

        res_next.code_unit  = unit;
        res_next.unit_valid = emit;
        res_next.string_end = item.last;
        res_next.unit_count = count_next;
        res_next.limit_hit  = stopped_next;

        if (item.last) begin
            bytes_left_next = '0;
            partial_next    = '0;
            seq_kind_next   = '0;
            count_next      = '0;
            stopped_next    = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            bytes_left_reg <= '0;
            partial_reg    <= '0;
            seq_kind_reg   <= '0;
            count_reg      <= '0;
            stopped_reg    <= 1'b0;
            out_valid_reg  <= 1'b0;
        end else begin
            if (take) begin
                bytes_left_reg <= bytes_left_next;
                partial_reg    <= partial_next;
                seq_kind_reg   <= seq_kind_next;
                count_reg      <= count_next;
                stopped_reg    <= stopped_next;
            end
            if (item_ready) begin
                out_valid_reg <= take && (emit || item.last);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (item_ready) begin
            out_reg <= res_next;
        end
    end

    assign res_valid = out_valid_reg;
    assign res       = out_reg;

    a_stop_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        stopped_reg |-> bytes_left_reg == '0)
        else $error("stopped inside a sequence");

    a_kind_clear: assert property (@(posedge aclk) disable iff (!aresetn)
        bytes_left_reg == '0 |-> seq_kind_reg == '0)
        else $error("sequence kind left over after sequence end");

    a_unit_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        out_valid_reg && !out_reg.unit_valid |-> out_reg.code_unit == '0)
        else $error("code unit nonzero without a unit");

endmodule
